@@ design/trec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trec_pkg: shared constants and types of the terrain-RGB colour map
// Gradient stops, stop colours, per-segment span and reciprocal tables, and
// the payload passed from the segment stages to the interpolation stages.
// ----------------------------------------------------------------------------
package trec_pkg;

	localparam int NUM_STOPS   = 10;
	localparam int NUM_SEGS    = NUM_STOPS - 1;
	localparam int NUM_CH      = 3;
	localparam int CH_W        = 8;
	localparam int CODE_W      = 3 * CH_W;
	localparam int ELEV_W      = CODE_W + 1;
	localparam int SEG_W       = 4;
	localparam int OFF_W       = 14;
	localparam int DELTA_W     = CH_W + 1;
	localparam int MAG_W       = 7;
	localparam int RECIP_W     = 12;
	localparam int RECIP_SHIFT = 22;
	localparam int PROD_W      = OFF_W + MAG_W;
	localparam int WIDE_W      = PROD_W + RECIP_W;
	localparam int QUOT_W      = WIDE_W - RECIP_SHIFT;
	localparam int MUL_W       = QUOT_W + OFF_W;
	localparam int REM_W       = OFF_W + 1;
	localparam int SUM_W       = QUOT_W + 1;
	localparam int ELEV_BIAS   = 100000;

	// Gradient stops in decimetres
	localparam int STOP_DM [NUM_STOPS] = '{
		-2000, 0, 1500, 5000, 6500, 8500, 11000, 15000, 30000, 38000
	};

	// Stop colours, red / green / blue
	localparam logic [CH_W-1:0] STOP_RGB [NUM_STOPS][NUM_CH] = '{
		'{8'd20,  8'd60,  8'd150},
		'{8'd65,  8'd150, 8'd210},
		'{8'd180, 8'd220, 8'd140},
		'{8'd120, 8'd185, 8'd80},
		'{8'd190, 8'd160, 8'd90},
		'{8'd160, 8'd120, 8'd60},
		'{8'd130, 8'd90,  8'd50},
		'{8'd180, 8'd170, 8'd160},
		'{8'd220, 8'd215, 8'd210},
		'{8'd255, 8'd255, 8'd255}
	};

	// Segment widths in decimetres
	localparam logic [OFF_W-1:0] SEG_SPAN [NUM_SEGS] = '{
		14'd2000, 14'd1500, 14'd3500, 14'd1500, 14'd2000,
		14'd2500, 14'd4000, 14'd15000, 14'd8000
	};

	// floor(2^RECIP_SHIFT / span) for each segment
	localparam logic [RECIP_W-1:0] SEG_RECIP [NUM_SEGS] = '{
		12'd2097, 12'd2796, 12'd1198, 12'd2796, 12'd2097,
		12'd1677, 12'd1048, 12'd279,  12'd524
	};

	typedef logic signed [ELEV_W-1:0] elev_t;
	typedef logic [SEG_W-1:0]         seg_idx_t;

	// One pixel after segment lookup
	typedef struct packed {
		logic [OFF_W-1:0]               off;
		logic [OFF_W-1:0]               span;
		logic [RECIP_W-1:0]             recip;
		logic [NUM_CH-1:0][CH_W-1:0]    base;
		logic [NUM_CH-1:0][MAG_W-1:0]   mag;
		logic [NUM_CH-1:0]              neg;
	} seg_t;

endpackage

@@ design/trec_pixel_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trec_pixel_if: terrain-RGB pixel channel
// Valid/ready channel carrying one encoded elevation pixel per request.
// ----------------------------------------------------------------------------
interface trec_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;

	modport source (output valid, output in_red, output in_green, output in_blue,
		input ready);
	modport sink (input valid, input in_red, input in_green, input in_blue,
		output ready);
endinterface

@@ design/trec_colour_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trec_colour_if: gradient colour channel
// Valid/ready channel carrying one display colour per request.
// ----------------------------------------------------------------------------
interface trec_colour_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;

	modport source (output valid, output out_red, output out_green, output out_blue,
		input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		output ready);
endinterface

@@ design/trec_seg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trec_seg: elevation decode and segment lookup
// Stage 1 decodes the pixel and finds its gradient segment; stage 2 forms
// the offset into the segment and fetches the segment constants.
// ----------------------------------------------------------------------------
module trec_seg (
	input  logic          clk,
	input  logic          arst_n,
	trec_pixel_if.sink    pix,
	output logic          seg_valid,
	input  logic          seg_ready,
	output trec_pkg::seg_t seg
);
	import trec_pkg::*;

	logic     valid_s1, valid_s2;
	logic     rdy_s1, rdy_s2;
	elev_t    elev_c, elev_s1;
	seg_idx_t idx_c, idx_s1;
	logic     below_c, above_c, below_s1, above_s1;
	seg_t     seg_c, seg_s2;

	// Stall chain: a stage takes a request when empty or when it moves on
	assign rdy_s2    = !valid_s2 || seg_ready;
	assign rdy_s1    = !valid_s1 || rdy_s2;
	assign pix.ready = rdy_s1;

	// Decode elevation, find its segment and flag elevations outside the gradient
	always_comb begin
		elev_c  = elev_t'({1'b0, pix.in_red, pix.in_green, pix.in_blue}) - elev_t'(ELEV_BIAS);
		idx_c   = '0;
		for (int i = 1; i < NUM_STOPS - 1; i++) begin
			if (elev_c >= elev_t'(STOP_DM[i])) begin
				idx_c = SEG_W'(i);
			end
		end
		below_c = elev_c <= elev_t'(STOP_DM[0]);
		above_c = elev_c >= elev_t'(STOP_DM[NUM_STOPS-1]);
	end

	// Offset and segment constants; outside the gradient hold the end colour
	always_comb begin
		logic signed [DELTA_W-1:0] d;
		logic [SEG_W-1:0]          nxt;
		elev_t                     off_full;
		nxt       = SEG_W'(idx_s1 + 1'b1);
		off_full  = elev_s1 - elev_t'(STOP_DM[idx_s1]);
		seg_c.off   = (below_s1 || above_s1) ? '0 : OFF_W'(off_full);
		seg_c.span  = SEG_SPAN[idx_s1];
		seg_c.recip = SEG_RECIP[idx_s1];
		for (int k = 0; k < NUM_CH; k++) begin
			d = $signed({1'b0, STOP_RGB[nxt][k]}) - $signed({1'b0, STOP_RGB[idx_s1][k]});
			if (below_s1) begin
				seg_c.base[k] = STOP_RGB[0][k];
				seg_c.neg[k]  = 1'b0;
				seg_c.mag[k]  = '0;
			end else if (above_s1) begin
				seg_c.base[k] = STOP_RGB[NUM_STOPS-1][k];
				seg_c.neg[k]  = 1'b0;
				seg_c.mag[k]  = '0;
			end else begin
				seg_c.base[k] = STOP_RGB[idx_s1][k];
				seg_c.neg[k]  = d[DELTA_W-1];
				seg_c.mag[k]  = d[DELTA_W-1] ? MAG_W'(-d) : MAG_W'(d);
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= pix.valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (rdy_s1 && pix.valid) begin
			elev_s1  <= elev_c;
			idx_s1   <= idx_c;
			below_s1 <= below_c;
			above_s1 <= above_c;
		end
		if (rdy_s2 && valid_s1) begin
			seg_s2 <= seg_c;
		end
	end

	assign seg_valid = valid_s2;
	assign seg       = seg_s2;

endmodule

@@ design/trec_lerp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trec_lerp: per-channel interpolation
// Scales the offset by the colour step, divides by the segment span through
// a reciprocal multiply with one correction step, and adds the base colour.
// ----------------------------------------------------------------------------
module trec_lerp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           seg_valid,
	output logic           seg_ready,
	input  trec_pkg::seg_t seg,
	trec_colour_if.source  col
);
	import trec_pkg::*;

	logic valid_s3, valid_s4, valid_s5, valid_s6;
	logic rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	logic [NUM_CH-1:0][PROD_W-1:0] n_c, n_s3, n_s4, n_s5;
	logic [NUM_CH-1:0][QUOT_W-1:0] q0_c, q0_s4, q0_s5;
	logic [NUM_CH-1:0][MUL_W-1:0]  qs_c, qs_s5;
	logic [NUM_CH-1:0][CH_W-1:0]   base_s3, base_s4, base_s5;
	logic [NUM_CH-1:0]             neg_s3, neg_s4, neg_s5;
	logic [OFF_W-1:0]              span_s3, span_s4, span_s5;
	logic [RECIP_W-1:0]            recip_s3;
	logic [NUM_CH-1:0][CH_W-1:0]   res_c, res_s6;

	// Stall chain
	assign rdy_s6    = !valid_s6 || col.ready;
	assign rdy_s5    = !valid_s5 || rdy_s6;
	assign rdy_s4    = !valid_s4 || rdy_s5;
	assign rdy_s3    = !valid_s3 || rdy_s4;
	assign seg_ready = rdy_s3;

	// Offset times colour step magnitude
	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			n_c[k] = {{MAG_W{1'b0}}, seg.off} * {{OFF_W{1'b0}}, seg.mag[k]};
		end
	end

	// Quotient estimate: one low or exact
	always_comb begin
		logic [WIDE_W-1:0] p;
		for (int k = 0; k < NUM_CH; k++) begin
			p        = {{RECIP_W{1'b0}}, n_s3[k]} * {{PROD_W{1'b0}}, recip_s3};
			q0_c[k]  = p[WIDE_W-1:RECIP_SHIFT];
		end
	end

	// Estimate times span
	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			qs_c[k] = {{OFF_W{1'b0}}, q0_s4[k]} * {{QUOT_W{1'b0}}, span_s4};
		end
	end

	// Correct quotient, round toward minus infinity, add base colour
	always_comb begin
		logic [REM_W-1:0]  r0;
		logic [REM_W-1:0]  rem;
		logic              adj;
		logic [QUOT_W-1:0] q;
		logic [QUOT_W-1:0] qc;
		logic [SUM_W-1:0]  sum;
		for (int k = 0; k < NUM_CH; k++) begin
			r0  = REM_W'({{(MUL_W-PROD_W){1'b0}}, n_s5[k]} - qs_s5[k]);
			adj = r0 >= {1'b0, span_s5};
			rem = adj ? REM_W'(r0 - {1'b0, span_s5}) : r0;
			q   = QUOT_W'(q0_s5[k] + QUOT_W'(adj));
			qc  = QUOT_W'(q + QUOT_W'(rem != '0));
			if (neg_s5[k]) begin
				sum = {{(SUM_W-CH_W){1'b0}}, base_s5[k]} - {1'b0, qc};
			end else begin
				sum = {{(SUM_W-CH_W){1'b0}}, base_s5[k]} + {1'b0, q};
			end
			res_c[k] = sum[CH_W-1:0];
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				valid_s3 <= seg_valid;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
			if (rdy_s5) begin
				valid_s5 <= valid_s4;
			end
			if (rdy_s6) begin
				valid_s6 <= valid_s5;
			end
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (rdy_s3 && seg_valid) begin
			n_s3     <= n_c;
			base_s3  <= seg.base;
			neg_s3   <= seg.neg;
			span_s3  <= seg.span;
			recip_s3 <= seg.recip;
		end
		if (rdy_s4 && valid_s3) begin
			n_s4    <= n_s3;
			q0_s4   <= q0_c;
			base_s4 <= base_s3;
			neg_s4  <= neg_s3;
			span_s4 <= span_s3;
		end
		if (rdy_s5 && valid_s4) begin
			n_s5    <= n_s4;
			q0_s5   <= q0_s4;
			qs_s5   <= qs_c;
			base_s5 <= base_s4;
			neg_s5  <= neg_s4;
			span_s5 <= span_s4;
		end
		if (rdy_s6 && valid_s5) begin
			res_s6 <= res_c;
		end
	end

	assign col.valid     = valid_s6;
	assign col.out_red   = res_s6[0];
	assign col.out_green = res_s6[1];
	assign col.out_blue  = res_s6[2];

endmodule

@@ design/terrain_rgb_elevation_colormap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terrain_rgb_elevation_colormap: terrain-RGB pixel to gradient colour
// Use: drive terrain-RGB pixels into "terrain" and take display colours
// from "colour"; both are valid/ready channels, a request moves when valid
// and ready are high at a clock edge.
// Each pixel decodes to elevation in decimetres, R*65536+G*256+B-100000,
// and is mapped through a ten-stop gradient from -2000 dm to 38000 dm with
// exact integer interpolation rounded toward minus infinity.
// Throughput: one pixel per cycle; the six-stage pipeline (decode, segment
// constants, step multiply, reciprocal multiply, span multiply, correction)
// takes a new pixel every cycle while the sink keeps up.
// Stall: when the sink holds ready low, the colour holds in the output
// stage and the empty stages behind it keep filling; ready on "terrain" falls
// only once every stage holds a pixel. Nothing is dropped or repeated.
// Reset: arst_n low empties the pipeline at once; no pixel is lost in flight
// after reset as none is held, and the block takes pixels from the first
// cycle after release.
// ----------------------------------------------------------------------------
module terrain_rgb_elevation_colormap (
	input  logic          clk,
	input  logic          arst_n,
	trec_pixel_if.sink    terrain,
	trec_colour_if.source colour
);
	import trec_pkg::*;

	logic seg_valid;
	logic seg_ready;
	seg_t seg;

	// Decode and segment lookup
	trec_seg u_seg (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (terrain),
		.seg_valid (seg_valid),
		.seg_ready (seg_ready),
		.seg       (seg)
	);

	// Interpolation and output register
	trec_lerp u_lerp (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_ready (seg_ready),
		.seg       (seg),
		.col       (colour)
	);

endmodule

@@ tb/terrain_rgb_elevation_colormap_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terrain_rgb_elevation_colormap_tb: self-checking bench for the colour map
// Drives terrain-RGB pixels through the valid/ready pixel channel. Each
// accepted pixel is decoded to its elevation and mapped through the
// ten-stop gradient here, so an expected colour is known before the block
// produces one. Colours are compared in order on the colour channel. The
// stimulus starts with stop edges and byte extremes, then moves on to
// random pixels, mostly inside the gradient. Both sides idle at random but
// for a steady stretch, and the sink holds off long enough once to back the pipeline up.
// ----------------------------------------------------------------------------
module terrain_rgb_elevation_colormap_tb;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_PIXELS = 850;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int BACKLOG_AFTER = 300;
	localparam int BACKLOG_HOLD  = 80;
	localparam int ELEV_OFFSET  = 100000;
	localparam int GRAD_STOPS   = 10;

	// Gradient stops in decimetres and their colours
	localparam int GRAD_ELEV [GRAD_STOPS] = '{
		-2000, 0, 1500, 5000, 6500, 8500, 11000, 15000, 30000, 38000
	};
	localparam int GRAD_RGB [GRAD_STOPS][3] = '{
		'{20, 60, 150}, '{65, 150, 210}, '{180, 220, 140}, '{120, 185, 80},
		'{190, 160, 90}, '{160, 120, 60}, '{130, 90, 50}, '{180, 170, 160},
		'{220, 215, 210}, '{255, 255, 255}
	};

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} colour_t;

	// Expected colours of accepted pixels, checked in order of arrival
	class colour_scoreboard;
		colour_t expected_colours[$];
		int      mismatches;
		int      failures;

		function new();
			mismatches = 0;
			failures   = 0;
		endfunction

		// Decode the pixel to elevation and interpolate along the gradient
		function colour_t map_elevation(logic [23:0] code);
			int      elev;
			int      seg;
			int      off;
			int      span;
			int      num;
			int      quot;
			int      ch [3];
			colour_t c;
			elev = int'({8'd0, code}) - ELEV_OFFSET;
			if (elev <= GRAD_ELEV[0]) begin
				for (int k = 0; k < 3; k++) ch[k] = GRAD_RGB[0][k];
			end else if (elev >= GRAD_ELEV[GRAD_STOPS-1]) begin
				for (int k = 0; k < 3; k++) ch[k] = GRAD_RGB[GRAD_STOPS-1][k];
			end else begin
				seg = 0;
				while (seg < GRAD_STOPS - 2 && elev >= GRAD_ELEV[seg+1])
					seg++;
				off  = elev - GRAD_ELEV[seg];
				span = GRAD_ELEV[seg+1] - GRAD_ELEV[seg];
				for (int k = 0; k < 3; k++) begin
					num = off * (GRAD_RGB[seg+1][k] - GRAD_RGB[seg][k]);
					// round toward minus infinity on a falling channel
					if (num >= 0)
						quot = num / span;
					else
						quot = -((-num + span - 1) / span);
					ch[k] = GRAD_RGB[seg][k] + quot;
				end
			end
			c.red   = ch[0][7:0];
			c.green = ch[1][7:0];
			c.blue  = ch[2][7:0];
			return c;
		endfunction

		function void note_pixel(logic [23:0] code);
			expected_colours.push_back(map_elevation(code));
		endfunction

		function void check_colour(colour_t got);
			colour_t want;
			if (expected_colours.size() == 0) begin
				failures++;
				mismatches++;
				if (mismatches <= 10)
					$display("colour %h/%h/%h arrived with no pixel waiting",
						got.red, got.green, got.blue);
				return;
			end
			want = expected_colours.pop_front();
			if (got !== want) begin
				failures++;
				mismatches++;
				if (mismatches <= 10)
					$display("colour mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
						want.red, want.green, want.blue, got.red, got.green, got.blue);
			end
		endfunction

		function int pending();
			return expected_colours.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles;
	int   colours_seen;
	bit   steady_run;

	trec_pixel_if  terrain_ch ();
	trec_colour_if colour_ch ();

	colour_scoreboard sb;

	terrain_rgb_elevation_colormap u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.terrain(terrain_ch),
		.colour (colour_ch)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Abort a run that goes on past the cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Idle length: mostly none, some short, a few long
	function automatic int idle_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return 0;
		else if (pick < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one pixel after a random gap, none in the steady stretch, and hold it until the request moves
	task automatic send_pixel(input logic [23:0] code);
		int gap;
		gap = steady_run ? 0 : idle_gap();
		if (gap > 0) begin
			terrain_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		terrain_ch.valid    <= 1'b1;
		terrain_ch.in_red   <= code[23:16];
		terrain_ch.in_green <= code[15:8];
		terrain_ch.in_blue  <= code[7:0];
		do
			@(posedge clk);
		while (!terrain_ch.ready);
		sb.note_pixel(code);
	endtask

	task automatic send_elevation(input int elev);
		logic [23:0] code;
		code = 24'(elev + ELEV_OFFSET);
		send_pixel(code);
	endtask

	// Colour sink: take results, stall at random, back up once for a long hold
	initial begin
		int  hold_left;
		bit  backlog_done;
		colour_t got;
		hold_left    = 0;
		backlog_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (colour_ch.valid && colour_ch.ready) begin
				got.red   = colour_ch.out_red;
				got.green = colour_ch.out_green;
				got.blue  = colour_ch.out_blue;
				sb.check_colour(got);
				colours_seen++;
			end
			if (!backlog_done && colours_seen >= BACKLOG_AFTER) begin
				backlog_done = 1'b1;
				hold_left    = BACKLOG_HOLD;
			end else if (hold_left == 0 && !steady_run) begin
				hold_left = idle_gap();
			end
			if (hold_left > 0) begin
				colour_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				colour_ch.ready <= 1'b1;
			end
		end
	end

	// Reset, directed pixels, random pixels, drain and verdict
	initial begin
		int          pick;
		int          elev;
		logic [23:0] code;
		sb           = new();
		cycles       = 0;
		colours_seen = 0;
		steady_run   = 1'b0;
		arst_n              <= 1'b0;
		terrain_ch.valid    <= 1'b0;
		terrain_ch.in_red   <= 8'd0;
		terrain_ch.in_green <= 8'd0;
		terrain_ch.in_blue  <= 8'd0;
		colour_ch.ready     <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// byte extremes, both clamps and every stop edge
		send_pixel(24'h000000);
		send_pixel(24'hFFFFFF);
		send_elevation(-2001);
		send_elevation(-2000);
		send_elevation(-1999);
		send_elevation(-1);
		send_elevation(0);
		send_elevation(1499);
		send_elevation(1500);
		send_elevation(4999);
		send_elevation(5000);
		send_elevation(6499);
		send_elevation(6500);
		send_elevation(8499);
		send_elevation(8500);
		send_elevation(10999);
		send_elevation(11000);
		send_elevation(14999);
		send_elevation(15000);
		send_elevation(29999);
		send_elevation(30000);
		send_elevation(37999);
		send_elevation(38000);
		send_elevation(38001);

		// random pixels: mostly inside the gradient, some near stops, some raw
		for (int n = 0; n < RANDOM_PIXELS; n++) begin
			steady_run = (n >= 450 && n < 550);
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				code = 24'($urandom);
				send_pixel(code);
			end else begin
				if (pick < 35)
					elev = GRAD_ELEV[$urandom_range(0, GRAD_STOPS - 1)]
						+ int'($urandom_range(0, 6)) - 3;
				else
					elev = int'($urandom_range(0, 40200)) - 2100;
				send_elevation(elev);
			end
		end
		steady_run = 1'b0;
		terrain_ch.valid <= 1'b0;

		// drain the pipeline, then allow for stray results
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.failures == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ filelist.f @@
design/trec_pkg.sv
design/trec_pixel_if.sv
design/trec_colour_if.sv
design/trec_seg.sv
design/trec_lerp.sv
design/terrain_rgb_elevation_colormap.sv
tb/terrain_rgb_elevation_colormap_tb.sv
